[src/hvn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hvn_pkg;

  localparam logic [31:0] HASH_MUL_X = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Z = 32'd668265263;
  localparam logic [31:0] HASH_ADD   = 32'd20260509;
  localparam logic [31:0] HASH_MIX   = 32'd1274126177;
  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [17:0] THREE_Q16  = 18'd196608;

  localparam logic [15:0] FREQ_RESET = 16'd9;
  localparam logic [31:0] SALT_RESET = 32'd13;

  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CELL_FREQ = 2'd0,
    REG_HASH_SALT = 2'd1,
    REG_SPARE_A   = 2'd2,
    REG_SPARE_B   = 2'd3
  } cfg_reg_t;

  // queue status towards front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

[src/hashed_value_noise_2d_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake         Payload
// in_       in   valid / stall     coord_x, coord_z (16 b each)
// out_      out  valid / stall     noise_value (16 b, Q0.16)
// cfg_      in   valid / ready     index (0 freq, 1 salt), data (32 b)
//
// One request per cycle while nothing stalls; COORD_BITS+16 divider stages,
// then the queue and nine back-end stages.
// Divider throughput is set by one quotient bit per pipeline stage.
// Synchronous active-low reset: freq 9, salt 13, all pipes and queue empty.
// Back end stalls only while its output register holds an untaken request;
// the divider stalls only when the 4-entry queue is full.
module hashed_value_noise_2d_top #(
  parameter int COORD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_coord_x,
  input  wire logic [15:0] in_coord_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_noise_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [hvn_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  import hvn_pkg::*;

  localparam int QW = COORD_BITS + 16;

  logic [15:0]   freq_r;
  logic [31:0]   salt_r;
  logic [15:0]   freq_eff;

  logic          front_en, front_vld;
  logic [QW-1:0] qx, qz, rx, rz;
  q_stat_t       qs;
  logic          push, pop, back_en;

  // register file; any index outside the list is dropped
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= FREQ_RESET;
      salt_r <= SALT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CELL_FREQ: freq_r <= cfg_data[15:0];
        REG_HASH_SALT: salt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero frequency behaves as one
  assign freq_eff = (freq_r == 16'd0) ? 16'd1 : freq_r;

  // front: divider holds when its last stage cannot drain into the queue
  assign front_en = !(front_vld && qs.full);
  assign in_stall = !front_en;
  assign push     = front_vld && !qs.full;

  hvn_div #(.CB(COORD_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (front_en),
    .in_vld (in_valid),
    .x      (COORD_BITS'(in_coord_x)),
    .z      (COORD_BITS'(in_coord_z)),
    .freq   (freq_eff),
    .out_vld(front_vld),
    .qx     (qx),
    .qz     (qz)
  );

  hvn_fifo #(.W(2 * QW)) u_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .wdata({qx, qz}),
    .pop  (pop),
    .rdata({rx, rz}),
    .stat (qs)
  );

  // back: whole pipe moves while the output register is free or taken
  assign back_en = !out_valid || !out_stall;
  assign pop     = back_en && !qs.empty;

  hvn_back #(.CB(COORD_BITS)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (back_en),
    .in_vld (pop),
    .cx     (rx[QW-1:16]),
    .tx     (rx[15:0]),
    .cz     (rz[QW-1:16]),
    .tz     (rz[15:0]),
    .salt   (salt_r),
    .out_vld(out_valid),
    .noise  (out_noise_value)
  );

endmodule
`default_nettype wire

[src/hvn_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Front: pipelined restoring divider, one quotient bit per stage, x and z lanes.
// Quotient of (coord << 16) / f: upper bits cell index, low 16 bits weight.
module hvn_div #(
  parameter int CB = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_vld,
  input  wire logic [CB-1:0]     x,
  input  wire logic [CB-1:0]     z,
  input  wire logic [15:0]       freq,
  output logic                   out_vld,
  output logic [CB+15:0]         qx,
  output logic [CB+15:0]         qz
);
  import hvn_pkg::*;

  localparam int N = CB + 16;

  logic [N-1:0]  vld_r;
  logic [N-1:0]  numx_r [N];
  logic [N-1:0]  numz_r [N];
  logic [15:0]   remx_r [N];
  logic [15:0]   remz_r [N];

  // valid bits move as one shift register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_vld};
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [N-1:0] nx_in, nz_in;
    logic [15:0]  rx_in, rz_in;
    logic [16:0]  tx, tz;
    logic         gx, gz;

    if (s == 0) begin : g_first
      assign nx_in = {x, 16'd0};
      assign nz_in = {z, 16'd0};
      assign rx_in = 16'd0;
      assign rz_in = 16'd0;
    end else begin : g_next
      assign nx_in = numx_r[s-1];
      assign nz_in = numz_r[s-1];
      assign rx_in = remx_r[s-1];
      assign rz_in = remz_r[s-1];
    end

    assign tx = {rx_in, nx_in[N-1]};
    assign tz = {rz_in, nz_in[N-1]};
    assign gx = tx >= {1'b0, freq};
    assign gz = tz >= {1'b0, freq};

    always_ff @(posedge clk) begin
      if (en) begin
        numx_r[s] <= {nx_in[N-2:0], gx};
        numz_r[s] <= {nz_in[N-2:0], gz};
        remx_r[s] <= gx ? 16'(tx - {1'b0, freq}) : tx[15:0];
        remz_r[s] <= gz ? 16'(tz - {1'b0, freq}) : tz[15:0];
      end
    end
  end

  assign out_vld = vld_r[N-1];
  assign qx      = numx_r[N-1];
  assign qz      = numz_r[N-1];

endmodule
`default_nettype wire

[src/hvn_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// Short queue between divider front and hash/blend back.
module hvn_fifo #(
  parameter int W = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [W-1:0]     wdata,
  input  wire logic             pop,
  output logic [W-1:0]          rdata,
  output hvn_pkg::q_stat_t      stat
);
  import hvn_pkg::*;

  logic [W-1:0] mem [4];
  logic [1:0]   wp_r, rp_r;
  logic [2:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, push} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wdata;
    end
  end

  assign rdata      = mem[rp_r];
  assign stat.full  = cnt_r == 3'd4;
  assign stat.empty = cnt_r == 3'd0;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty)) else $error("pop from empty queue");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 3'd1) else $error("count slip");
`endif

endmodule
`default_nettype wire

[src/hvn_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// Back: salt, corner hashes, smoothstep, two-level blend, output register.
module hvn_back #(
  parameter int CB = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_vld,
  input  wire logic [CB-1:0]  cx,
  input  wire logic [15:0]    tx,
  input  wire logic [CB-1:0]  cz,
  input  wire logic [15:0]    tz,
  input  wire logic [31:0]    salt,
  output logic                out_vld,
  output logic [15:0]         noise
);
  import hvn_pkg::*;

  logic [8:0]  vld_r;
  // S1
  logic [31:0] ax0_r, ax1_r, az0_r, az1_r;
  logic [15:0] tx1_r, tz1_r;
  // S2
  logic [31:0] mx0_r, mx1_r, mz0_r, mz1_r, ttx2_r, ttz2_r;
  logic [17:0] kx2_r, kz2_r;
  // S3
  logic [31:0] m00_r, m10_r, m01_r, m11_r, ttx3_r, ttz3_r;
  logic [17:0] kx3_r, kz3_r;
  logic [31:0] n00, n10, n01, n11;
  // S4
  logic [31:0] p00_r, p10_r, p01_r, p11_r;
  logic [49:0] sxp_r, szp_r;
  // S5
  logic [15:0] v00_r, v10_r, v01_r, v11_r, sx_r, sz5_r;
  // S6
  logic [32:0] pl0_r, pl1_r, ph0_r, ph1_r;
  logic [15:0] sz6_r;
  // S7
  logic [15:0] lo_r, hi_r, sz7_r;
  logic [32:0] sum_lo, sum_hi;
  // S8
  logic [32:0] q0_r, q1_r;
  logic [32:0] sum_out;
  // S9
  logic [15:0] noise_r;

  assign n00 = mx0_r + mz0_r + HASH_ADD;
  assign n10 = mx1_r + mz0_r + HASH_ADD;
  assign n01 = mx0_r + mz1_r + HASH_ADD;
  assign n11 = mx1_r + mz1_r + HASH_ADD;

  assign sum_lo  = pl0_r + pl1_r;
  assign sum_hi  = ph0_r + ph1_r;
  assign sum_out = q0_r + q1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[7:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax0_r  <= 32'(cx) + salt;
      ax1_r  <= 32'(cx) + salt + 32'd1;
      az0_r  <= 32'(cz) + salt;
      az1_r  <= 32'(cz) + salt + 32'd1;
      tx1_r  <= tx;
      tz1_r  <= tz;

      mx0_r  <= ax0_r * HASH_MUL_X;
      mx1_r  <= ax1_r * HASH_MUL_X;
      mz0_r  <= az0_r * HASH_MUL_Z;
      mz1_r  <= az1_r * HASH_MUL_Z;
      ttx2_r <= 32'(tx1_r) * 32'(tx1_r);
      ttz2_r <= 32'(tz1_r) * 32'(tz1_r);
      kx2_r  <= THREE_Q16 - {1'b0, tx1_r, 1'b0};
      kz2_r  <= THREE_Q16 - {1'b0, tz1_r, 1'b0};

      m00_r  <= n00 ^ (n00 >> 13);
      m10_r  <= n10 ^ (n10 >> 13);
      m01_r  <= n01 ^ (n01 >> 13);
      m11_r  <= n11 ^ (n11 >> 13);
      ttx3_r <= ttx2_r;
      ttz3_r <= ttz2_r;
      kx3_r  <= kx2_r;
      kz3_r  <= kz2_r;

      p00_r  <= m00_r * HASH_MIX;
      p10_r  <= m10_r * HASH_MIX;
      p01_r  <= m01_r * HASH_MIX;
      p11_r  <= m11_r * HASH_MIX;
      sxp_r  <= 50'(ttx3_r) * 50'(kx3_r);
      szp_r  <= 50'(ttz3_r) * 50'(kz3_r);

      // low half of h ^ (h >> 16)
      v00_r  <= p00_r[15:0] ^ p00_r[31:16];
      v10_r  <= p10_r[15:0] ^ p10_r[31:16];
      v01_r  <= p01_r[15:0] ^ p01_r[31:16];
      v11_r  <= p11_r[15:0] ^ p11_r[31:16];
      sx_r   <= sxp_r[47:32];
      sz5_r  <= szp_r[47:32];

      pl0_r  <= 33'(v00_r) * 33'(ONE_Q16 - {1'b0, sx_r});
      pl1_r  <= 33'(v10_r) * 33'(sx_r);
      ph0_r  <= 33'(v01_r) * 33'(ONE_Q16 - {1'b0, sx_r});
      ph1_r  <= 33'(v11_r) * 33'(sx_r);
      sz6_r  <= sz5_r;

      lo_r   <= sum_lo[31:16];
      hi_r   <= sum_hi[31:16];
      sz7_r  <= sz6_r;

      q0_r   <= 33'(lo_r) * 33'(ONE_Q16 - {1'b0, sz7_r});
      q1_r   <= 33'(hi_r) * 33'(sz7_r);

      noise_r <= sum_out[31:16];
    end
  end

  assign out_vld = vld_r[8];
  assign noise   = noise_r;

endmodule
`default_nettype wire
